// File: hdl/dar_pkg.sv
package dar_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FORMAT   = 2'd1,
        ST_NXDOMAIN = 2'd2,
        ST_SERVFAIL = 2'd3
    } status_t;

    // parser phases, one-hot
    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_NAME    = 7'b0000010,
        PH_LABEL   = 7'b0000100,
        PH_POINTER = 7'b0001000,
        PH_QTRAIL  = 7'b0010000,
        PH_RRFIX   = 7'b0100000,
        PH_RDATA   = 7'b1000000
    } phase_t;

    // one result item
    typedef struct packed {
        logic [31:0] address;
        status_t     status;
    } result_t;

    // header byte offsets (odd byte of each 16-bit word)
    localparam int          HDR_OFF_W       = 4;
    localparam logic [3:0]  OFF_ID_LO       = 4'd1;
    localparam logic [3:0]  OFF_FLAGS_LO    = 4'd3;
    localparam logic [3:0]  OFF_QDCOUNT_LO  = 4'd5;
    localparam logic [3:0]  OFF_ANCOUNT_LO  = 4'd7;
    localparam logic [3:0]  OFF_HDR_END     = 4'd11;
    localparam logic [3:0]  OFF_SAT         = 4'hF;

    // header flag fields
    localparam logic [15:0] QR_MASK         = 16'h8000;
    localparam logic [3:0]  RCODE_NXDOMAIN  = 4'd3;
    localparam logic [3:0]  RCODE_NOERROR   = 4'd0;

    // name bytes
    localparam logic [7:0]  PTR_MASK        = 8'hC0;
    localparam logic [7:0]  NAME_END        = 8'h00;

    // fixed parts of question and answer records, counted as bytes remaining
    localparam logic [15:0] QTRAIL_LEN      = 16'd4;
    localparam logic [15:0] RRFIX_LEN       = 16'd10;
    localparam logic [15:0] RR_TYPE_HI      = 16'd10;
    localparam logic [15:0] RR_TYPE_LO      = 16'd9;
    localparam logic [15:0] RR_LEN_HI       = 16'd2;
    localparam logic [15:0] RR_LEN_LO       = 16'd1;

    // the record we look for
    localparam logic [15:0] TYPE_A          = 16'd1;
    localparam logic [15:0] A_RDLENGTH      = 16'd4;

endpackage

// File: hdl/dns_a_record_response_parser.sv
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata = data_byte, s_tlast = last_byte
// m_        out  m_tvalid/m_tready    m_tdata = status, address
// cfg_      in   cfg_valid/cfg_ready  cfg_data = expected_id
//
// one byte per cycle unless a last byte waits for a busy result register;
// a result passes the input register, then the result register
// aresetn is synchronous, active low; clears parser state and expected_id
// bytes without last flow through while a result waits; a last byte holds in
// the input register only until the result register is free
module dns_a_record_response_parser #(
    parameter int MAX_RECORDS = 64,
    parameter int MAX_HOPS    = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] status, [33:2] address, [39:34] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import dar_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic [15:0] expected_id_reg;
    logic        step_en;
    result_t     step_result;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_id_reg <= 16'd0;
        end else if (cfg_valid) begin
            expected_id_reg <= cfg_data;
        end
    end

    // a byte steps the parser unless its result has nowhere to go
    assign step_en  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    dar_parse_core #(
        .MAX_RECORDS (MAX_RECORDS),
        .MAX_HOPS    (MAX_HOPS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .data_byte   (in_byte_reg),
        .last_byte   (in_last_reg),
        .expected_id (expected_id_reg),
        .result      (step_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && in_last_reg) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.address, out_reg.status};

    // a last byte never overwrites a result still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && in_last_reg |-> !out_valid_reg || m_tready)
        else $error("result register overrun");

    // address is zero on every failing result
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.status != ST_OK |-> out_reg.address == 32'd0)
        else $error("nonzero address on failing result");

endmodule

// File: hdl/dar_parse_core.sv
module dar_parse_core #(
    parameter int MAX_RECORDS = 64,
    parameter int MAX_HOPS    = 128
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic [15:0]       expected_id,
    output dar_pkg::result_t  result
);
    import dar_pkg::*;

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int HOP_W = $clog2(MAX_HOPS + 1);
    localparam logic [15:0]      MAX_REC_16 = 16'(MAX_RECORDS);
    localparam logic [CNT_W-1:0] MAX_REC_C  = CNT_W'(MAX_RECORDS);
    localparam logic [HOP_W-1:0] MAX_HOP_C  = HOP_W'(MAX_HOPS);

    // parser state
    logic [HDR_OFF_W-1:0] off_reg, off_next;
    phase_t               phase_reg, phase_next;
    logic [7:0]           hbyte_reg, hbyte_next;
    logic [CNT_W-1:0]     qleft_reg, qleft_next;
    logic [CNT_W-1:0]     aleft_reg, aleft_next;
    logic [15:0]          skip_reg, skip_next;
    logic [HOP_W-1:0]     hops_reg, hops_next;
    logic [15:0]          rtype_reg, rtype_next;
    logic [15:0]          rlen_reg, rlen_next;
    logic [31:0]          addr_reg, addr_next;
    status_t              status_reg, status_next;
    logic                 decided_reg, decided_next;

    logic [15:0]          word;
    logic [CNT_W-1:0]     word_cap;
    logic [HOP_W-1:0]     hops_inc;
    logic [15:0]          skip_dec;
    logic                 is_a;
    logic                 qleft_zero;

    assign word       = {hbyte_reg, data_byte};
    assign word_cap   = (word > MAX_REC_16) ? MAX_REC_C : word[CNT_W-1:0];
    assign hops_inc   = hops_reg + HOP_W'(1);
    assign skip_dec   = skip_reg - 16'd1;
    assign is_a       = (rtype_reg == TYPE_A) && (rlen_reg == A_RDLENGTH);
    assign qleft_zero = (qleft_reg == '0);

    // one byte of parsing
    always_comb begin
        off_next     = (off_reg == OFF_SAT) ? off_reg : off_reg + HDR_OFF_W'(1);
        phase_next   = phase_reg;
        hbyte_next   = hbyte_reg;
        qleft_next   = qleft_reg;
        aleft_next   = aleft_reg;
        skip_next    = skip_reg;
        hops_next    = hops_reg;
        rtype_next   = rtype_reg;
        rlen_next    = rlen_reg;
        addr_next    = addr_reg;
        status_next  = status_reg;
        decided_next = decided_reg;

        if (!decided_reg) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (!off_reg[0]) begin
                        hbyte_next = data_byte;
                    end else begin
                        unique case (off_reg)
                            OFF_ID_LO: begin
                                if (word != expected_id) begin
                                    decided_next = 1'b1;
                                    status_next  = ST_FORMAT;
                                end
                            end
                            OFF_FLAGS_LO: begin
                                if ((word & QR_MASK) == 16'd0) begin
                                    decided_next = 1'b1;
                                    status_next  = ST_FORMAT;
                                end else if (word[3:0] == RCODE_NXDOMAIN) begin
                                    status_next = ST_NXDOMAIN;
                                end else if (word[3:0] != RCODE_NOERROR) begin
                                    status_next = ST_SERVFAIL;
                                end
                            end
                            OFF_QDCOUNT_LO: qleft_next = word_cap;
                            OFF_ANCOUNT_LO: aleft_next = word_cap;
                            OFF_HDR_END: begin
                                if (status_reg != ST_OK) begin
                                    decided_next = 1'b1;
                                end else if (aleft_reg == '0) begin
                                    decided_next = 1'b1;
                                    status_next  = ST_NXDOMAIN;
                                end else begin
                                    phase_next = PH_NAME;
                                    hops_next  = '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                PH_NAME: begin
                    if (data_byte == NAME_END) begin
                        // end of name: question trailer or answer fixed part
                        phase_next = qleft_zero ? PH_RRFIX : PH_QTRAIL;
                        skip_next  = qleft_zero ? RRFIX_LEN : QTRAIL_LEN;
                    end else if ((data_byte & PTR_MASK) == PTR_MASK) begin
                        phase_next = PH_POINTER;
                    end else begin
                        hops_next = hops_inc;
                        if (hops_inc >= MAX_HOP_C) begin
                            decided_next = 1'b1;
                            status_next  = ST_FORMAT;
                        end else begin
                            skip_next  = {8'd0, data_byte};
                            phase_next = PH_LABEL;
                        end
                    end
                end
                PH_LABEL: begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        phase_next = PH_NAME;
                    end
                end
                PH_POINTER: begin
                    phase_next = qleft_zero ? PH_RRFIX : PH_QTRAIL;
                    skip_next  = qleft_zero ? RRFIX_LEN : QTRAIL_LEN;
                end
                PH_QTRAIL: begin
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        qleft_next = qleft_reg - CNT_W'(1);
                        phase_next = PH_NAME;
                        hops_next  = '0;
                    end
                end
                PH_RRFIX: begin
                    // capture type and rdlength from the fixed part
                    unique case (skip_reg)
                        RR_TYPE_HI: rtype_next = {data_byte, 8'd0};
                        RR_TYPE_LO: rtype_next = {rtype_reg[15:8], data_byte};
                        RR_LEN_HI:  rlen_next  = {data_byte, 8'd0};
                        RR_LEN_LO:  rlen_next  = {rlen_reg[15:8], data_byte};
                        default: ;
                    endcase
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        if (rlen_next == 16'd0) begin
                            aleft_next = aleft_reg - CNT_W'(1);
                            if (aleft_reg == CNT_W'(1)) begin
                                decided_next = 1'b1;
                                status_next  = ST_NXDOMAIN;
                            end else begin
                                phase_next = PH_NAME;
                                hops_next  = '0;
                            end
                        end else begin
                            addr_next  = '0;
                            skip_next  = rlen_next;
                            phase_next = PH_RDATA;
                        end
                    end
                end
                PH_RDATA: begin
                    if (is_a) begin
                        addr_next = {addr_reg[23:0], data_byte};
                    end
                    skip_next = skip_dec;
                    if (skip_dec == 16'd0) begin
                        if (is_a) begin
                            decided_next = 1'b1;
                            status_next  = ST_OK;
                        end else begin
                            aleft_next = aleft_reg - CNT_W'(1);
                            if (aleft_reg == CNT_W'(1)) begin
                                decided_next = 1'b1;
                                status_next  = ST_NXDOMAIN;
                            end else begin
                                phase_next = PH_NAME;
                                hops_next  = '0;
                            end
                        end
                    end
                end
                default: begin
                    decided_next = 1'b1;
                    status_next  = ST_FORMAT;
                end
            endcase
        end
    end

    // result of this byte, meaningful when it is the last one
    always_comb begin
        result.status  = decided_next ? status_next : ST_FORMAT;
        result.address = (decided_next && status_next == ST_OK) ? addr_next : 32'd0;
    end

    // state registers, cleared after the last byte of each message
    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && last_byte)) begin
            off_reg     <= '0;
            phase_reg   <= PH_HEADER;
            hbyte_reg   <= '0;
            qleft_reg   <= '0;
            aleft_reg   <= '0;
            skip_reg    <= '0;
            hops_reg    <= '0;
            rtype_reg   <= '0;
            rlen_reg    <= '0;
            addr_reg    <= '0;
            status_reg  <= ST_OK;
            decided_reg <= 1'b0;
        end else if (step_en) begin
            off_reg     <= off_next;
            phase_reg   <= phase_next;
            hbyte_reg   <= hbyte_next;
            qleft_reg   <= qleft_next;
            aleft_reg   <= aleft_next;
            skip_reg    <= skip_next;
            hops_reg    <= hops_next;
            rtype_reg   <= rtype_next;
            rlen_reg    <= rlen_next;
            addr_reg    <= addr_next;
            status_reg  <= status_next;
            decided_reg <= decided_next;
        end
    end

    // message state is back to idle after a last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && last_byte |=> phase_reg == PH_HEADER && !decided_reg && off_reg == '0)
        else $error("parser state not cleared after last byte");

    // record counts never exceed the cap
    assert property (@(posedge aclk) disable iff (!aresetn)
        qleft_reg <= MAX_REC_C && aleft_reg <= MAX_REC_C)
        else $error("record count above cap");

    // name walking only happens with answers still pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_HEADER && !decided_reg |-> aleft_reg != '0)
        else $error("parsing past the last answer");

endmodule
